// File: rtl/core/vsc_pkg.sv
// Package for the version string compare block.
// Types, character codes and classify functions; no dependencies.
`timescale 1ns / 1ps

package vsc_pkg;

  localparam int NUM_PARTS      = 5;
  localparam int LOCAL_REGS     = 5;
  localparam int PART_W         = 20;
  localparam int IDX_W          = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int CFG_IDX_W      = 3;
  localparam int MAX_PART_VALUE = 1000000;
  localparam int ACC_W          = PART_W + 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic signed [1:0] ORD_LESS    = -2'sd1;
  localparam logic signed [1:0] ORD_EQUAL   = 2'sd0;
  localparam logic signed [1:0] ORD_GREATER = 2'sd1;

  typedef logic [PART_W-1:0] part_t;
  typedef part_t [NUM_PARTS-1:0] parts_t;
  typedef part_t [LOCAL_REGS-1:0] loc_parts_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_AFTER_DOT,
    PH_TRAIL,
    PH_ERROR
  } phase_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// File: rtl/core/vsc_parse.sv
// Character parser: phase, part index, digit accumulator and stored parts.
// Depends on vsc_pkg.
`timescale 1ns / 1ps

module vsc_parse import vsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] char_code,
  output logic       term_ok,
  output parts_t     remote_view
);

  localparam logic [IDX_W:0]   LAST_IDX = (IDX_W + 1)'(NUM_PARTS);
  localparam logic [ACC_W-1:0] MAX_ACC  = ACC_W'(MAX_PART_VALUE);

  phase_t            phase, phase_next;
  logic [IDX_W-1:0]  idx, idx_next;
  part_t             acc, acc_next;
  parts_t            parts, parts_next;
  logic              line_ended, line_ended_next;

  logic [ACC_W-1:0]  dval;
  logic [ACC_W-1:0]  acc10;
  logic [ACC_W-1:0]  sum_first;
  logic [ACC_W-1:0]  sum_cont;
  logic              idx_ok;

  assign dval      = ACC_W'(char_code - CH_ZERO);
  assign acc10     = ({4'b0, acc} << 3) + ({4'b0, acc} << 1);
  assign sum_first = dval;
  assign sum_cont  = acc10 + dval;
  assign idx_ok    = ({1'b0, idx} < LAST_IDX);

  always_comb begin
    phase_next      = phase;
    idx_next        = idx;
    acc_next        = acc;
    parts_next      = parts;
    line_ended_next = line_ended;
    if (step) begin
      if (char_code == CH_NUL) begin
        phase_next      = PH_LEAD;
        idx_next        = '0;
        acc_next        = '0;
        parts_next      = '0;
        line_ended_next = 1'b0;
      end else if (!line_ended) begin
        if (char_code == CH_LF || char_code == CH_CR) begin
          line_ended_next = 1'b1;
        end else begin
          case (phase)
            PH_LEAD, PH_AFTER_DOT: begin
              if (is_digit(char_code)) begin
                if (sum_first > MAX_ACC) begin
                  phase_next = PH_ERROR;
                  acc_next   = '0;
                end else begin
                  phase_next = PH_DIGITS;
                  acc_next   = sum_first[PART_W-1:0];
                end
              end else if (!(phase == PH_LEAD && is_blank(char_code))) begin
                phase_next = PH_ERROR;
              end
            end
            PH_DIGITS: begin
              if (is_digit(char_code)) begin
                if (sum_cont > MAX_ACC) begin
                  phase_next = PH_ERROR;
                  acc_next   = '0;
                end else begin
                  acc_next   = sum_cont[PART_W-1:0];
                end
              end else if (char_code == CH_DOT) begin
                if (idx_ok) parts_next[idx] = acc;
                if (({1'b0, idx} + 1'b1) >= LAST_IDX) begin
                  phase_next = PH_ERROR;
                end else begin
                  idx_next   = idx + 1'b1;
                  acc_next   = '0;
                  phase_next = PH_AFTER_DOT;
                end
              end else if (is_blank(char_code)) begin
                if (idx_ok) parts_next[idx] = acc;
                phase_next = PH_TRAIL;
              end else begin
                phase_next = PH_ERROR;
              end
            end
            PH_TRAIL: begin
              if (!is_blank(char_code)) phase_next = PH_ERROR;
            end
            default: begin
              phase_next = PH_ERROR;
            end
          endcase
        end
      end
    end
  end

  // Parts as seen by a terminator: an open part counts as stored.
  always_comb begin
    term_ok = (phase == PH_DIGITS) || (phase == PH_TRAIL);
    for (int i = 0; i < NUM_PARTS; i++) begin
      if (phase == PH_DIGITS && idx == IDX_W'(i)) begin
        remote_view[i] = acc;
      end else begin
        remote_view[i] = parts[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEAD;
      idx        <= '0;
      acc        <= '0;
      parts      <= '0;
      line_ended <= 1'b0;
    end else begin
      phase      <= phase_next;
      idx        <= idx_next;
      acc        <= acc_next;
      parts      <= parts_next;
      line_ended <= line_ended_next;
    end
  end

endmodule

// File: rtl/core/vsc_compare.sv
// Lexicographic compare of remote parts against local parts, major first.
// Depends on vsc_pkg.
`timescale 1ns / 1ps

module vsc_compare import vsc_pkg::*; (
  input  parts_t             remote_parts,
  input  loc_parts_t         loc_parts,
  output logic signed [1:0]  order
);

  part_t loc;

  always_comb begin
    order = ORD_EQUAL;
    loc   = '0;
    for (int i = NUM_PARTS - 1; i >= 0; i--) begin
      loc = (i < LOCAL_REGS) ? loc_parts[i] : '0;
      if (remote_parts[i] < loc) begin
        order = ORD_LESS;
      end else if (remote_parts[i] > loc) begin
        order = ORD_GREATER;
      end
    end
  end

endmodule

// File: rtl/core/version_string_compare.sv
// A terminator request is held in the input register, then its result in the result register.
// Throughput: one character per cycle, set by the input register feeding the
// parser; a terminator waits only while the result register is still full.
// Reset (synchronous, rst high): parser in leading-whitespace phase, parts and
// local registers zero, no request or result held.
`timescale 1ns / 1ps

module version_string_compare import vsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            char_code,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  valid_res,
  output logic signed [1:0]     order,
  output logic                  newer,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PART_W-1:0]     cfg_data
);

  logic              held;
  logic [7:0]        held_char;
  logic              is_term;
  logic              step;
  logic              term_ok;
  parts_t            remote_view;
  loc_parts_t        loc_parts;
  logic signed [1:0] cmp_order;

  assign is_term  = (held_char == CH_NUL);
  assign step     = held && (!is_term || !out_valid || out_ready);
  assign in_ready = !held || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (step) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) held_char <= char_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loc_parts <= '0;
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(LOCAL_REGS)) begin
      loc_parts[cfg_index] <= cfg_data;
    end
  end

  vsc_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .char_code   (held_char),
    .term_ok     (term_ok),
    .remote_view (remote_view)
  );

  vsc_compare u_compare (
    .remote_parts (remote_view),
    .loc_parts    (loc_parts),
    .order        (cmp_order)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && is_term) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && is_term) begin
      valid_res <= term_ok;
      order     <= term_ok ? cmp_order : ORD_EQUAL;
      newer     <= term_ok && (cmp_order == ORD_GREATER);
    end
  end

endmodule

// File: rtl/core/vsc_checker.sv
// Port-level checks for version_string_compare, bound to the top level.
// Depends on vsc_pkg.
`timescale 1ns / 1ps

module vsc_assert import vsc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              valid_res,
  input logic signed [1:0] order,
  input logic              newer
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(valid_res) && $stable(order)
      && $stable(newer))
    else $error("result changed while stalled");

  a_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> order == ORD_EQUAL && !newer)
    else $error("invalid result with nonzero order");

  a_newer: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> newer == (valid_res && order == ORD_GREATER))
    else $error("newer disagrees with order");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> order == ORD_LESS || order == ORD_EQUAL || order == ORD_GREATER)
    else $error("order code out of range");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind version_string_compare vsc_assert u_vsc_assert (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .valid_res (valid_res),
  .order     (order),
  .newer     (newer)
);
